@@ hdl/sfs_pkg.sv @@
// Shared types and constants of the sprite frame sequencer.
package sfs_pkg;

    // Field and state widths
    localparam int DT_W     = 16;
    localparam int DUR_W    = 20;
    localparam int CNT_W    = 9;
    localparam int FRAME_W  = 8;
    localparam int ACC_W    = 21;
    localparam int DIV_W    = 22;
    localparam int OUT_W    = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;

    // Largest clip length; the frame index is 8 bits wide
    localparam int MAX_FRAMES = 256;
    localparam int CNT_CAP_I  = (MAX_FRAMES < 256) ? MAX_FRAMES : 256;
    localparam logic [CNT_W-1:0] CNT_CAP = CNT_W'(CNT_CAP_I);

    // Register reset values
    localparam logic [DUR_W-1:0] DURATION_RST = DUR_W'(16667);
    localparam logic [CNT_W-1:0] COUNT_RST    = CNT_W'(1);
    localparam logic             LOOP_RST     = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DURATION = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LOOP     = 2'd2;

    // Operation codes
    localparam logic OP_TICK    = 1'b0;
    localparam logic OP_RESTART = 1'b1;

    // Divider iteration count, one quotient bit per cycle
    localparam int DIV_STEPS = DIV_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    // Commands from controller to datapath
    typedef struct packed {
        logic capture;
        logic do_restart;
        logic load_acc;
        logic start_div1;
        logic fin_div1;
        logic start_div2;
        logic fin_div2;
        logic load_out;
    } sfs_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic is_restart;
        logic active;
        logic acc_ge_dur;
        logic loop_mode;
        logic div_done;
    } sfs_status_t;

endpackage

@@ hdl/sprite_frame_sequencer_core.sv @@
// Top level of the sprite frame sequencer: controller plus datapath.
//
// Channel   Direction  Transaction carries
// s_axis    in         tdata[15:0] delta_time, tuser[0] operation
// m_axis    out        tdata[7:0] frame_index, [8] active, [9] finished, [15:10] zero
// cfg       in         cfg_index (0 duration, 1 count, 2 loop), cfg_data
//
// A restart or an inactive or non-advancing tick goes from accept through decide to write.
// A tick that advances runs one division in one-shot mode and two in loop mode,
// both on the shared 22-step restoring divider.
// One item is in flight at a time; a new one is taken while a result waits on m_axis.
// A stalled m_axis holds the finished result; reset restores the register defaults
// and clears the clip state.
module sprite_frame_sequencer_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [sfs_pkg::DT_W-1:0]       s_axis_tdata,   // [15:0] delta_time
    input  logic                           s_axis_tuser,   // [0] operation
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [sfs_pkg::OUT_W-1:0]      m_axis_tdata,   // [7:0] frame_index, [8] active,
                                                           // [9] finished
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [sfs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sfs_pkg::CFG_DATA_W-1:0] cfg_data
);

    sfs_pkg::sfs_cmd_t    cmd;
    sfs_pkg::sfs_status_t status;

    // Accept configuration at any time
    assign cfg_ready = 1'b1;

    sfs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .status    (status),
        .cmd       (cmd)
    );

    sfs_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_op     (s_axis_tuser),
        .in_dt     (s_axis_tdata),
        .cfg_we    (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_data  (m_axis_tdata)
    );

endmodule

@@ hdl/sfs_div.sv @@
// Restoring divider, one quotient bit per cycle.
module sfs_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [sfs_pkg::DIV_W-1:0]  dividend,
    input  logic [sfs_pkg::DUR_W-1:0]  divisor,
    output logic [sfs_pkg::DIV_W-1:0]  quotient,
    output logic [sfs_pkg::DUR_W-1:0]  remainder,
    output logic                       done
);

    logic [sfs_pkg::DUR_W-1:0]     rem_reg, rem_next;
    logic [sfs_pkg::DIV_W-1:0]     quo_reg, quo_next;
    logic [sfs_pkg::DUR_W-1:0]     dvs_reg, dvs_next;
    logic [sfs_pkg::DIV_CNT_W-1:0] step_reg, step_next;
    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [sfs_pkg::DUR_W:0]       shifted;
    logic [sfs_pkg::DUR_W:0]       diff;
    logic                          fits;

    // Shift in the next dividend bit and try a subtract
    assign shifted = {rem_reg, quo_reg[sfs_pkg::DIV_W-1]};
    assign diff    = shifted - {1'b0, dvs_reg};
    assign fits    = (shifted >= {1'b0, dvs_reg});

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
            step_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next  = fits ? diff[sfs_pkg::DUR_W-1:0] : shifted[sfs_pkg::DUR_W-1:0];
            quo_next  = {quo_reg[sfs_pkg::DIV_W-2:0], fits};
            step_next = step_reg + 1'b1;
            if (step_reg == sfs_pkg::DIV_CNT_W'(sfs_pkg::DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Hold iteration control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    // Hold operands and partial results
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign quotient  = quo_reg;
    assign remainder = rem_reg;
    assign done      = done_reg;

endmodule

@@ hdl/sfs_datapath.sv @@
// Datapath: configuration, animation state, divider and result register.
module sfs_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  sfs_pkg::sfs_cmd_t             cmd,
    output sfs_pkg::sfs_status_t          status,
    input  logic                          in_op,
    input  logic [sfs_pkg::DT_W-1:0]      in_dt,
    input  logic                          cfg_we,
    input  logic [sfs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sfs_pkg::CFG_DATA_W-1:0] cfg_data,
    output logic [sfs_pkg::OUT_W-1:0]     out_data
);

    logic [sfs_pkg::DUR_W-1:0]   duration_reg;
    logic [sfs_pkg::CNT_W-1:0]   count_reg;
    logic                        loop_reg;
    logic                        active_reg;
    logic [sfs_pkg::FRAME_W-1:0] frame_reg;
    logic [sfs_pkg::ACC_W-1:0]   elapsed_reg;
    logic                        done_reg;
    logic                        op_reg;
    logic [sfs_pkg::DT_W-1:0]    dt_reg;
    logic [sfs_pkg::DIV_W-1:0]   sum_reg;
    logic [sfs_pkg::OUT_W-1:0]   out_reg;

    logic [sfs_pkg::DUR_W-1:0]   dur_eff;
    logic [sfs_pkg::CNT_W-1:0]   cnt_eff;
    logic [sfs_pkg::CNT_W-1:0]   last_frame;
    logic [sfs_pkg::ACC_W:0]     acc_wide;
    logic [sfs_pkg::ACC_W-1:0]   acc_sum;
    logic [sfs_pkg::DIV_W-1:0]   frame_sum;
    logic [sfs_pkg::DIV_W-1:0]   last_wide;
    logic                        at_last;
    logic [sfs_pkg::FRAME_W-1:0] clamped;

    logic                        div_start;
    logic [sfs_pkg::DIV_W-1:0]   div_dividend;
    logic [sfs_pkg::DUR_W-1:0]   div_divisor;
    logic [sfs_pkg::DIV_W-1:0]   div_quotient;
    logic [sfs_pkg::DUR_W-1:0]   div_remainder;
    logic                        div_done;

    // Substitute legal values for out-of-range registers
    always_comb
    begin
        dur_eff = (duration_reg == '0) ? sfs_pkg::DUR_W'(1) : duration_reg;
        priority if (count_reg == '0)
            cnt_eff = sfs_pkg::CNT_W'(1);
        else if (count_reg > sfs_pkg::CNT_CAP)
            cnt_eff = sfs_pkg::CNT_CAP;
        else
            cnt_eff = count_reg;
    end
    assign last_frame = cnt_eff - 1'b1;

    // Accumulate elapsed time, wrapping at the accumulator width
    assign acc_wide = {1'b0, elapsed_reg} + {{(sfs_pkg::ACC_W + 1 - sfs_pkg::DT_W){1'b0}}, dt_reg};
    assign acc_sum  = acc_wide[sfs_pkg::ACC_W-1:0];

    // Advance by the quotient and clamp for one-shot clips
    assign frame_sum = {{(sfs_pkg::DIV_W - sfs_pkg::FRAME_W){1'b0}}, frame_reg} + div_quotient;
    assign last_wide = {{(sfs_pkg::DIV_W - sfs_pkg::CNT_W){1'b0}}, last_frame};
    assign at_last   = (frame_sum >= last_wide);
    assign clamped   = at_last ? last_frame[sfs_pkg::FRAME_W-1:0]
                               : frame_sum[sfs_pkg::FRAME_W-1:0];

    // Share the divider between both divisions
    assign div_start    = cmd.start_div1 | cmd.start_div2;
    assign div_dividend = cmd.start_div2 ? sum_reg : {1'b0, acc_sum};
    assign div_divisor  = cmd.start_div2
                        ? {{(sfs_pkg::DUR_W - sfs_pkg::CNT_W){1'b0}}, cnt_eff} : dur_eff;

    sfs_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .quotient  (div_quotient),
        .remainder (div_remainder),
        .done      (div_done)
    );

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            duration_reg <= sfs_pkg::DURATION_RST;
            count_reg    <= sfs_pkg::COUNT_RST;
            loop_reg     <= sfs_pkg::LOOP_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                sfs_pkg::REG_DURATION: duration_reg <= cfg_data;
                sfs_pkg::REG_COUNT:    count_reg    <= cfg_data[sfs_pkg::CNT_W-1:0];
                sfs_pkg::REG_LOOP:     loop_reg     <= cfg_data[0];
                default:               ;
            endcase
        end
    end

    // Update animation state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg  <= 1'b0;
            frame_reg   <= '0;
            elapsed_reg <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.do_restart)
            begin
                active_reg  <= 1'b1;
                frame_reg   <= '0;
                elapsed_reg <= '0;
                done_reg    <= 1'b0;
            end
            if (cmd.load_acc)
                elapsed_reg <= acc_sum;
            if (cmd.fin_div1)
            begin
                elapsed_reg <= {{(sfs_pkg::ACC_W - sfs_pkg::DUR_W){1'b0}}, div_remainder};
                if (!loop_reg)
                begin
                    frame_reg <= clamped;
                    if (at_last)
                        done_reg <= 1'b1;
                end
            end
            if (cmd.fin_div2)
                frame_reg <= div_remainder[sfs_pkg::FRAME_W-1:0];
        end
    end

    // Capture the item, the running frame sum and the result word
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg <= in_op;
            dt_reg <= in_dt;
        end
        if (cmd.fin_div1)
            sum_reg <= frame_sum;
        if (cmd.load_out)
            out_reg <= {{(sfs_pkg::OUT_W - sfs_pkg::FRAME_W - 2){1'b0}},
                        done_reg, active_reg, frame_reg};
    end

    assign status.is_restart = (op_reg == sfs_pkg::OP_RESTART);
    assign status.active     = active_reg;
    assign status.acc_ge_dur = ({1'b0, acc_sum} >= {{(sfs_pkg::ACC_W + 1 - sfs_pkg::DUR_W){1'b0}},
                                                   dur_eff});
    assign status.loop_mode  = loop_reg;
    assign status.div_done   = div_done;
    assign out_data          = out_reg;

endmodule

@@ hdl/sfs_ctrl.sv @@
// Controller: sequences one item through the datapath and drives the handshakes.
module sfs_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    input  sfs_pkg::sfs_status_t  status,
    output sfs_pkg::sfs_cmd_t     cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_DIV1,
        ST_START2,
        ST_DIV2,
        ST_WRITE
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || out_ready;

    // Decode commands and next state
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                priority if (status.is_restart)
                begin
                    cmd.do_restart = 1'b1;
                    state_next     = ST_WRITE;
                end
                else if (!status.active)
                    state_next = ST_WRITE;
                else if (!status.acc_ge_dur)
                begin
                    cmd.load_acc = 1'b1;
                    state_next   = ST_WRITE;
                end
                else
                begin
                    cmd.start_div1 = 1'b1;
                    state_next     = ST_DIV1;
                end
            end
            ST_DIV1:
            begin
                if (status.div_done)
                begin
                    cmd.fin_div1 = 1'b1;
                    state_next   = status.loop_mode ? ST_START2 : ST_WRITE;
                end
            end
            ST_START2:
            begin
                cmd.start_div2 = 1'b1;
                state_next     = ST_DIV2;
            end
            ST_DIV2:
            begin
                if (status.div_done)
                begin
                    cmd.fin_div2 = 1'b1;
                    state_next   = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                if (out_free)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Hold state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

@@ verif/tb_sprite_frame_sequencer_core.sv @@
// Self-checking testbench for the sprite frame sequencer core.
`timescale 1ns / 1ps

module tb_sprite_frame_sequencer_core;

    localparam int CYCLE_LIMIT   = 500000;
    localparam int SINK_HOLD_LEN = 600;
    localparam int DRAIN_CYCLES  = 64;
    localparam int RAND_PHASES   = 10;
    localparam int PHASE_CMDS    = 103;

    typedef struct {
        logic                     op;
        logic [sfs_pkg::DT_W-1:0] dt;
    } anim_cmd_t;

    typedef struct packed {
        logic [sfs_pkg::FRAME_W-1:0] frame;
        logic                        active;
        logic                        finished;
    } frame_state_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    logic [sfs_pkg::DT_W-1:0]       s_axis_tdata = '0;
    logic                           s_axis_tuser = 1'b0;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    logic [sfs_pkg::OUT_W-1:0]      m_axis_tdata;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [sfs_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [sfs_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    anim_cmd_t    pending_cmds[$];
    frame_state_t expected_frames[$];
    int           mismatch_count = 0;

    // Flow control knobs (changed only between clock edges) and the hold-off state
    bit steady_flow = 1'b0;
    bit sink_hold_req = 1'b0;
    bit sink_hold_used = 1'b0;
    int sink_hold_left = 0;

    // Shadow copy of the clip registers
    logic [sfs_pkg::DUR_W-1:0] dur_reg = sfs_pkg::DURATION_RST;
    logic [sfs_pkg::CNT_W-1:0] count_reg = sfs_pkg::COUNT_RST;
    logic                      loop_reg = sfs_pkg::LOOP_RST;

    // Predicted animation state
    logic                        clip_on = 1'b0;
    logic [sfs_pkg::FRAME_W-1:0] frame_pos = '0;
    logic [sfs_pkg::ACC_W-1:0]   elapsed_us = '0;
    logic                        clip_done = 1'b0;

    sprite_frame_sequencer_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // Advance the animation state by one command and return the frame it reports
    function automatic frame_state_t step_animation(logic op, logic [sfs_pkg::DT_W-1:0] dt);
        int unsigned  dur;
        int unsigned  cnt;
        int unsigned  acc;
        int unsigned  sum;
        frame_state_t res;
        if (op == sfs_pkg::OP_RESTART)
        begin
            clip_on    = 1'b1;
            frame_pos  = '0;
            elapsed_us = '0;
            clip_done  = 1'b0;
        end
        else if (clip_on)
        begin
            dur = (dur_reg == 0) ? 1 : dur_reg;
            cnt = (count_reg == 0) ? 1 : count_reg;
            if (cnt > sfs_pkg::CNT_CAP_I)
                cnt = sfs_pkg::CNT_CAP_I;
            acc = (elapsed_us + dt) & ((1 << sfs_pkg::ACC_W) - 1);
            if (acc >= dur)
            begin
                sum = frame_pos + acc / dur;
                acc = acc % dur;
                if (loop_reg)
                    frame_pos = sfs_pkg::FRAME_W'(sum % cnt);
                else
                begin
                    if (sum > cnt - 1)
                        sum = cnt - 1;
                    frame_pos = sfs_pkg::FRAME_W'(sum);
                    if (sum >= cnt - 1)
                        clip_done = 1'b1;
                end
            end
            elapsed_us = sfs_pkg::ACC_W'(acc);
        end
        res.frame    = frame_pos;
        res.active   = clip_on;
        res.finished = clip_done;
        return res;
    endfunction

    // Source side: predict on each accepted transaction, then offer the next command
    always @(posedge clk or negedge rst_n)
    begin : source_drv
        anim_cmd_t nxt;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                expected_frames.push_back(step_animation(s_axis_tuser, s_axis_tdata));
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (pending_cmds.size() != 0 && (steady_flow || $urandom_range(99) >= 9))
                begin
                    nxt = pending_cmds.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser  <= nxt.op;
                    s_axis_tdata  <= nxt.dt;
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Count down the one long receiver hold-off
    always @(posedge clk)
    begin
        if (sink_hold_req && !sink_hold_used)
        begin
            sink_hold_left <= SINK_HOLD_LEN;
            sink_hold_used <= 1'b1;
        end
        else if (sink_hold_left != 0)
        begin
            sink_hold_left <= sink_hold_left - 1;
        end
    end

    // Sink side: check each result transaction, then pick the next ready level
    always @(posedge clk or negedge rst_n)
    begin : sink_mon
        frame_state_t exp_f;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_frames.size() == 0)
                begin
                    $error("result with no command outstanding: tdata 0x%04h", m_axis_tdata);
                    mismatch_count++;
                end
                else
                begin
                    exp_f = expected_frames.pop_front();
                    if (m_axis_tdata[7:0] !== exp_f.frame)
                    begin
                        $error("frame_index mismatch: expected %0d, got %0d",
                               exp_f.frame, m_axis_tdata[7:0]);
                        mismatch_count++;
                    end
                    if (m_axis_tdata[8] !== exp_f.active)
                    begin
                        $error("active mismatch: expected %0d, got %0d",
                               exp_f.active, m_axis_tdata[8]);
                        mismatch_count++;
                    end
                    if (m_axis_tdata[9] !== exp_f.finished)
                    begin
                        $error("finished mismatch: expected %0d, got %0d",
                               exp_f.finished, m_axis_tdata[9]);
                        mismatch_count++;
                    end
                    if (m_axis_tdata[sfs_pkg::OUT_W-1:10] !== '0)
                    begin
                        $error("padding mismatch: expected 0, got 0x%0h",
                               m_axis_tdata[sfs_pkg::OUT_W-1:10]);
                        mismatch_count++;
                    end
                end
            end
            m_axis_tready <= (sink_hold_left == 0) && (steady_flow || $urandom_range(99) >= 9);
        end
    end

    // Bound the run length
    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    task automatic queue_cmd(logic op, logic [sfs_pkg::DT_W-1:0] dt);
        anim_cmd_t c;
        c.op = op;
        c.dt = dt;
        pending_cmds.push_back(c);
    endtask

    // Hold until every command is accepted and every result has come back
    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_cmds.size() != 0 || s_axis_tvalid || expected_frames.size() != 0);
    endtask

    task automatic write_reg(logic [sfs_pkg::CFG_IDX_W-1:0] idx,
                             logic [sfs_pkg::CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            sfs_pkg::REG_DURATION: dur_reg = sfs_pkg::DUR_W'(val);
            sfs_pkg::REG_COUNT:    count_reg = sfs_pkg::CNT_W'(val);
            sfs_pkg::REG_LOOP:     loop_reg = val[0];
            default: ;
        endcase
        @(negedge clk);
    endtask

    task automatic set_clip(int unsigned dur, int unsigned cnt, bit lp);
        write_reg(sfs_pkg::REG_DURATION, sfs_pkg::CFG_DATA_W'(dur));
        write_reg(sfs_pkg::REG_COUNT, sfs_pkg::CFG_DATA_W'(cnt));
        write_reg(sfs_pkg::REG_LOOP, sfs_pkg::CFG_DATA_W'(lp));
    endtask

    initial
    begin : stimulus
        int unsigned dur;
        int unsigned cnt;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset clip settings: ticks before any restart are ignored
        queue_cmd(sfs_pkg::OP_TICK, 16'hFFFF);
        queue_cmd(sfs_pkg::OP_TICK, 16'h0000);
        queue_cmd(sfs_pkg::OP_RESTART, 16'hFFFF);
        queue_cmd(sfs_pkg::OP_TICK, 16'hFFFF);
        queue_cmd(sfs_pkg::OP_TICK, 16'h0000);
        wait_drained();

        // Zero duration and zero count act as one; one-shot finishes at once
        set_clip(0, 0, 0);
        queue_cmd(sfs_pkg::OP_RESTART, 16'h0000);
        queue_cmd(sfs_pkg::OP_TICK, 16'd5);
        queue_cmd(sfs_pkg::OP_TICK, 16'h0000);
        wait_drained();

        // Full 256-frame loop, wrap from the last frame to zero
        set_clip(1, 256, 1);
        queue_cmd(sfs_pkg::OP_RESTART, 16'h0000);
        queue_cmd(sfs_pkg::OP_TICK, 16'hAAAA);
        queue_cmd(sfs_pkg::OP_TICK, 16'h5555);
        queue_cmd(sfs_pkg::OP_TICK, 16'd1);
        queue_cmd(sfs_pkg::OP_TICK, 16'd200);
        wait_drained();

        // Shrink the clip under a running frame: no advance keeps it past the end
        set_clip(20'hFFFFF, 4, 0);
        queue_cmd(sfs_pkg::OP_TICK, 16'h0000);
        queue_cmd(sfs_pkg::OP_TICK, 16'hFFFF);
        wait_drained();
        set_clip(50000, 4, 0);
        queue_cmd(sfs_pkg::OP_TICK, 16'h0000);
        queue_cmd(sfs_pkg::OP_TICK, 16'h0000);
        wait_drained();

        // Count above the cap saturates; restart clears the finished flag
        set_clip(100, 511, 0);
        queue_cmd(sfs_pkg::OP_RESTART, 16'h0000);
        queue_cmd(sfs_pkg::OP_TICK, 16'hFFFF);
        queue_cmd(sfs_pkg::OP_RESTART, 16'hFFFF);
        queue_cmd(sfs_pkg::OP_TICK, 16'h5555);
        wait_drained();

        // Random clips, each phase with fresh settings
        for (int p = 0; p < RAND_PHASES; p++)
        begin
            case ($urandom_range(9))
                0:       dur = 0;
                1:       dur = 20'hFFFFF;
                2, 3, 4, 5: dur = $urandom_range(300, 1);
                6, 7:    dur = $urandom_range(20000, 1);
                default: dur = $urandom_range(20'hFFFFF, 1);
            endcase
            case ($urandom_range(9))
                0:       cnt = 0;
                1:       cnt = $urandom_range(511, 257);
                2:       cnt = 256;
                3, 4, 5, 6: cnt = $urandom_range(8, 1);
                default: cnt = $urandom_range(255, 1);
            endcase
            set_clip(dur, cnt, $urandom_range(1));
            steady_flow = (p == 6);
            if (p == 3)
                sink_hold_req = 1'b1;
            if ($urandom_range(1))
                queue_cmd(sfs_pkg::OP_RESTART, sfs_pkg::DT_W'($urandom));
            for (int i = 0; i < PHASE_CMDS; i++)
            begin
                if ($urandom_range(99) < 6)
                    queue_cmd(sfs_pkg::OP_RESTART, sfs_pkg::DT_W'($urandom));
                else
                    queue_cmd(sfs_pkg::OP_TICK,
                              sfs_pkg::DT_W'($urandom_range(16'hFFFF) >> $urandom_range(15)));
            end
            wait_drained();
            steady_flow = 1'b0;
        end

        // Let any stray result show up before the verdict
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_frames.size() != 0)
        begin
            $error("%0d results never arrived", expected_frames.size());
            mismatch_count++;
        end
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

@@ sprite_frame_sequencer_core.f @@
hdl/sfs_pkg.sv
hdl/sfs_div.sv
hdl/sfs_datapath.sv
hdl/sfs_ctrl.sv
hdl/sprite_frame_sequencer_core.sv
verif/tb_sprite_frame_sequencer_core.sv
